// ----- src/pbeq_pkg.sv -----
// Shared types, widths and codes of the parallel band-pass equalizer.
`default_nettype none

package pbeq_pkg;

    localparam int BAND_COUNT_DEF = 10;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEFF_BITS     = 32;

    localparam int COEFF_W   = (COEFF_BITS > 32) ? 32 : COEFF_BITS;
    localparam int Y_W       = 32;
    localparam int CF        = COEFF_BITS - 4;
    localparam int GF        = COEFF_BITS - 12;
    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int OPND_W    = (DIFF_W > Y_W) ? DIFF_W : Y_W;
    localparam int PROD_W    = COEFF_W + OPND_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int GP_W      = PROD_W + 1;
    localparam int CONTRIB_W = GP_W - GF;

    localparam logic signed [COEFF_W-1:0] GAIN_RESET =
        COEFF_W'(((64'sd636 <<< GF) + 64'sd500) / 64'sd1000);

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] SEL_FEEDBACK  = 2'd0;
    localparam logic [1:0] SEL_INPUT     = 2'd1;
    localparam logic [1:0] SEL_RECURSION = 2'd2;
    localparam logic [1:0] SEL_GAIN      = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
        logic [3:0]                    band_index;
        logic [1:0]                    table_select;
        logic signed [31:0]            table_value;
        logic                          block_last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_left;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic                          block_last_out;
    } out_item_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] c0;
        logic signed [COEFF_W-1:0] c1;
        logic signed [COEFF_W-1:0] c2;
        logic signed [COEFF_W-1:0] gain;
    } coef_entry_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [Y_W-1:0]         y1;
        logic signed [Y_W-1:0]         y2;
    } hist_entry_t;

    typedef struct packed {
        logic vld;
        logic ch;
        logic first;
        logic last;
    } band_tag_t;

endpackage

`default_nettype wire

// ----- src/pbeq_band_mac.sv -----
// Pipelined band section: products, recursion output, gain product, rounded contribution.
`default_nettype none

module pbeq_band_mac #(
    parameter int H_AW = 5
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  pbeq_pkg::band_tag_t                         rd_tag,
    input  wire  [H_AW-1:0]                             rd_addr,
    input  wire  signed [pbeq_pkg::SAMPLE_BITS-1:0]     x,
    input  pbeq_pkg::hist_entry_t                       hist,
    input  pbeq_pkg::coef_entry_t                       coef,
    output pbeq_pkg::band_tag_t                         wb_tag,
    output logic [H_AW-1:0]                             wb_addr,
    output pbeq_pkg::hist_entry_t                       wb_entry,
    output pbeq_pkg::band_tag_t                         sum_tag,
    output logic signed [pbeq_pkg::CONTRIB_W-1:0]       contrib
);

    localparam int PROD_W = pbeq_pkg::PROD_W;
    localparam int SUM_W  = pbeq_pkg::SUM_W;
    localparam int GP_W   = pbeq_pkg::GP_W;
    localparam int Y_W    = pbeq_pkg::Y_W;
    localparam int CF     = pbeq_pkg::CF;
    localparam int GF     = pbeq_pkg::GF;

    localparam logic signed [SUM_W-1:0] Y_RND = SUM_W'(1) <<< (CF - 3);
    localparam logic signed [GP_W-1:0]  G_RND = GP_W'(1) <<< (GF - 1);
    localparam logic signed [Y_W-1:0]   Y_HI  = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0]   Y_LO  = {1'b1, {(Y_W-1){1'b0}}};

    logic signed [pbeq_pkg::DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]            p2_next;
    logic signed [PROD_W-1:0]            p1_next;
    logic signed [PROD_W-1:0]            p0_next;
    logic signed [PROD_W-1:0]            p2_reg;
    logic signed [PROD_W-1:0]            p1_reg;
    logic signed [PROD_W-1:0]            p0_reg;
    pbeq_pkg::band_tag_t                 tag_p_reg;
    pbeq_pkg::band_tag_t                 tag_y_reg;
    pbeq_pkg::band_tag_t                 tag_g_reg;
    logic [H_AW-1:0]                     addr_p_reg;
    logic [H_AW-1:0]                     addr_y_reg;
    pbeq_pkg::hist_entry_t               ent_p_reg;
    pbeq_pkg::hist_entry_t               ent_y_reg;
    logic signed [pbeq_pkg::COEFF_W-1:0] gain_p_reg;
    logic signed [pbeq_pkg::COEFF_W-1:0] gain_y_reg;
    logic signed [SUM_W-1:0]             acc;
    logic signed [SUM_W-1:0]             rnd;
    logic signed [Y_W-1:0]               y_next;
    logic signed [Y_W-1:0]               y_reg;
    logic signed [PROD_W-1:0]            gp_next;
    logic signed [PROD_W-1:0]            gp_reg;
    logic signed [GP_W-1:0]              gp_rnd;

    always_comb
    begin
        diff    = pbeq_pkg::DIFF_W'(x) - pbeq_pkg::DIFF_W'(hist.x2);
        p2_next = PROD_W'(coef.c2) * PROD_W'(hist.y1);
        p1_next = PROD_W'(coef.c1) * PROD_W'(diff);
        p0_next = PROD_W'(coef.c0) * PROD_W'(hist.y2);
    end

    always_comb
    begin
        acc = SUM_W'(p2_reg >>> 2) + SUM_W'(p1_reg >>> 2) - SUM_W'(p0_reg >>> 2);
        rnd = (acc + Y_RND) >>> (CF - 2);
        if (rnd > SUM_W'(Y_HI))
        begin
            y_next = Y_HI;
        end
        else if (rnd < SUM_W'(Y_LO))
        begin
            y_next = Y_LO;
        end
        else
        begin
            y_next = Y_W'(rnd);
        end
    end

    assign gp_next = PROD_W'(y_reg) * PROD_W'(gain_y_reg);
    assign gp_rnd  = GP_W'(gp_reg) + G_RND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_p_reg <= '0;
            tag_y_reg <= '0;
            tag_g_reg <= '0;
        end
        else
        begin
            tag_p_reg <= rd_tag;
            tag_y_reg <= tag_p_reg;
            tag_g_reg <= tag_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg        <= p2_next;
        p1_reg        <= p1_next;
        p0_reg        <= p0_next;
        addr_p_reg    <= rd_addr;
        ent_p_reg.x1  <= x;
        ent_p_reg.x2  <= hist.x1;
        ent_p_reg.y1  <= '0;
        ent_p_reg.y2  <= hist.y1;
        gain_p_reg    <= coef.gain;
        y_reg         <= y_next;
        addr_y_reg    <= addr_p_reg;
        ent_y_reg     <= ent_p_reg;
        gain_y_reg    <= gain_p_reg;
        gp_reg        <= gp_next;
    end

    always_comb
    begin
        wb_tag      = tag_y_reg;
        wb_addr     = addr_y_reg;
        wb_entry    = ent_y_reg;
        wb_entry.y1 = y_reg;
    end

    assign sum_tag = tag_g_reg;
    assign contrib = pbeq_pkg::CONTRIB_W'(gp_rnd >>> GF);

endmodule

`default_nettype wire

// ----- src/parallel_bandpass_biquad_eq_core.sv -----
// A sample is accepted only while idle; its bands are issued to the band pipeline, drained, and
// the result registered for the response; only then is the next item taken, with one history
// memory read per band and channel. Table writes and clears are taken while idle and start no pass.
// Reset: coefficients zero, band gains 0.636, all band histories zero; no clearing pass,
// per-entry valid bits stand in for the reset contents.
`default_nettype none

module parallel_bandpass_biquad_eq_core #(
    parameter int BAND_COUNT = pbeq_pkg::BAND_COUNT_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  pbeq_pkg::in_item_t   req_item,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output pbeq_pkg::out_item_t  rsp_item
);

    localparam int HIST_DEPTH = 2 * BAND_COUNT;
    localparam int H_AW       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int BAND_AW    = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int SB         = pbeq_pkg::SAMPLE_BITS;
    localparam int ACC_W      = pbeq_pkg::CONTRIB_W + $clog2(BAND_COUNT + 1);

    localparam logic [BAND_AW-1:0]     LAST_BAND = BAND_AW'(BAND_COUNT - 1);
    localparam logic signed [ACC_W-1:0] S_HI = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] S_LO = ACC_W'(-(64'sd1 <<< (SB - 1)));

    pbeq_pkg::state_t            state_reg;
    pbeq_pkg::state_t            state_next;
    logic                        issue_en;
    logic                        rsp_load;
    logic                        req_fire;
    logic                        smp_acc;
    logic                        wr_acc;
    logic                        clr_acc;
    logic [BAND_AW-1:0]          wr_band;
    logic signed [pbeq_pkg::COEFF_W-1:0] wr_value;

    logic [BAND_AW-1:0]          band_cnt_reg;
    logic                        ch_cnt_reg;
    logic [H_AW-1:0]             hist_addr_reg;
    logic                        issue_last;

    logic signed [SB-1:0]        x_left_reg;
    logic signed [SB-1:0]        x_right_reg;
    logic                        last_reg;

    pbeq_pkg::coef_entry_t       coef_mem [BAND_COUNT];
    logic [BAND_COUNT-1:0][3:0]  coef_vld_reg;
    pbeq_pkg::coef_entry_t       coef_rd_reg;
    logic [3:0]                  coef_rd_vld_reg;
    pbeq_pkg::coef_entry_t       coef_eff;

    pbeq_pkg::hist_entry_t       hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]       hist_vld_reg;
    pbeq_pkg::hist_entry_t       hist_rd_reg;
    logic                        hist_rd_vld_reg;
    pbeq_pkg::hist_entry_t       hist_eff;

    pbeq_pkg::band_tag_t         rd_tag_reg;
    logic [H_AW-1:0]             rd_addr_reg;
    logic signed [SB-1:0]        x_cur;

    pbeq_pkg::band_tag_t         wb_tag;
    logic [H_AW-1:0]             wb_addr;
    pbeq_pkg::hist_entry_t       wb_entry;
    pbeq_pkg::band_tag_t         sum_tag;
    logic signed [pbeq_pkg::CONTRIB_W-1:0] contrib;

    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [SB-1:0]        acc_sat;
    logic signed [SB-1:0]        left_reg;
    logic signed [SB-1:0]        right_reg;
    logic                        fin;

    logic                        rsp_valid_reg;
    pbeq_pkg::out_item_t         rsp_item_reg;

    assign req_fire = req_valid && req_ready;
    assign smp_acc  = req_fire && (req_item.req_type == pbeq_pkg::REQ_SAMPLE);
    assign clr_acc  = req_fire && (req_item.req_type == pbeq_pkg::REQ_CLEAR);
    assign wr_acc   = req_fire && (req_item.req_type == pbeq_pkg::REQ_WRITE)
                      && (int'(req_item.band_index) < BAND_COUNT);
    assign wr_band  = BAND_AW'(req_item.band_index);
    assign wr_value = req_item.table_value[pbeq_pkg::COEFF_W-1:0];

    assign issue_last = ch_cnt_reg && (band_cnt_reg == LAST_BAND);
    assign fin        = sum_tag.vld && sum_tag.ch && sum_tag.last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbeq_pkg::ST_IDLE:
            begin
                if (smp_acc)
                begin
                    state_next = pbeq_pkg::ST_ISSUE;
                end
            end
            pbeq_pkg::ST_ISSUE:
            begin
                if (issue_last)
                begin
                    state_next = pbeq_pkg::ST_DRAIN;
                end
            end
            pbeq_pkg::ST_DRAIN:
            begin
                if (fin)
                begin
                    state_next = pbeq_pkg::ST_FLUSH;
                end
            end
            pbeq_pkg::ST_FLUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = pbeq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbeq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        issue_en  = 1'b0;
        rsp_load  = 1'b0;
        unique case (state_reg)
            pbeq_pkg::ST_IDLE:  req_ready = 1'b1;
            pbeq_pkg::ST_ISSUE: issue_en  = 1'b1;
            pbeq_pkg::ST_DRAIN: ;
            pbeq_pkg::ST_FLUSH: rsp_load  = !rsp_valid_reg || rsp_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbeq_pkg::ST_IDLE;
            band_cnt_reg  <= '0;
            ch_cnt_reg    <= 1'b0;
            hist_addr_reg <= '0;
            rd_tag_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (smp_acc)
            begin
                band_cnt_reg  <= '0;
                ch_cnt_reg    <= 1'b0;
                hist_addr_reg <= '0;
            end
            else if (issue_en)
            begin
                hist_addr_reg <= hist_addr_reg + 1'b1;
                if (band_cnt_reg == LAST_BAND)
                begin
                    band_cnt_reg <= '0;
                    ch_cnt_reg   <= 1'b1;
                end
                else
                begin
                    band_cnt_reg <= band_cnt_reg + 1'b1;
                end
            end
            rd_tag_reg.vld   <= issue_en;
            rd_tag_reg.ch    <= ch_cnt_reg;
            rd_tag_reg.first <= (band_cnt_reg == '0);
            rd_tag_reg.last  <= (band_cnt_reg == LAST_BAND);
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            x_left_reg  <= req_item.sample_left;
            x_right_reg <= req_item.sample_right;
            last_reg    <= req_item.block_last_in;
        end
        rd_addr_reg <= hist_addr_reg;
    end

    // coefficient memory: field writes, one registered read per cycle while issuing
    always_ff @(posedge clk)
    begin
        if (wr_acc)
        begin
            unique case (req_item.table_select)
                pbeq_pkg::SEL_FEEDBACK:  coef_mem[wr_band].c0   <= wr_value;
                pbeq_pkg::SEL_INPUT:     coef_mem[wr_band].c1   <= wr_value;
                pbeq_pkg::SEL_RECURSION: coef_mem[wr_band].c2   <= wr_value;
                pbeq_pkg::SEL_GAIN:      coef_mem[wr_band].gain <= wr_value;
                default: ;
            endcase
        end
        if (issue_en)
        begin
            coef_rd_reg     <= coef_mem[band_cnt_reg];
            coef_rd_vld_reg <= coef_vld_reg[band_cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
        end
        else if (wr_acc)
        begin
            coef_vld_reg[wr_band][req_item.table_select] <= 1'b1;
        end
    end

    // history memory: read one band entry, write it back after the product and recursion registers
    always_ff @(posedge clk)
    begin
        if (wb_tag.vld)
        begin
            hist_mem[wb_addr] <= wb_entry;
        end
        if (issue_en)
        begin
            hist_rd_reg     <= hist_mem[hist_addr_reg];
            hist_rd_vld_reg <= hist_vld_reg[hist_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
        end
        else if (clr_acc)
        begin
            hist_vld_reg <= '0;
        end
        else if (wb_tag.vld)
        begin
            hist_vld_reg[wb_addr] <= 1'b1;
        end
    end

    always_comb
    begin
        coef_eff.c0   = coef_rd_vld_reg[pbeq_pkg::SEL_FEEDBACK]  ? coef_rd_reg.c0 : '0;
        coef_eff.c1   = coef_rd_vld_reg[pbeq_pkg::SEL_INPUT]     ? coef_rd_reg.c1 : '0;
        coef_eff.c2   = coef_rd_vld_reg[pbeq_pkg::SEL_RECURSION] ? coef_rd_reg.c2 : '0;
        coef_eff.gain = coef_rd_vld_reg[pbeq_pkg::SEL_GAIN]      ? coef_rd_reg.gain
                                                                  : pbeq_pkg::GAIN_RESET;
        hist_eff      = hist_rd_vld_reg ? hist_rd_reg : '0;
        x_cur         = rd_tag_reg.ch ? x_right_reg : x_left_reg;
    end

    pbeq_band_mac #(
        .H_AW (H_AW)
    ) u_band_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_tag   (rd_tag_reg),
        .rd_addr  (rd_addr_reg),
        .x        (x_cur),
        .hist     (hist_eff),
        .coef     (coef_eff),
        .wb_tag   (wb_tag),
        .wb_addr  (wb_addr),
        .wb_entry (wb_entry),
        .sum_tag  (sum_tag),
        .contrib  (contrib)
    );

    always_comb
    begin
        acc_next = (sum_tag.first ? '0 : acc_reg) + ACC_W'(contrib);
        if (acc_next > S_HI)
        begin
            acc_sat = SB'(S_HI);
        end
        else if (acc_next < S_LO)
        begin
            acc_sat = SB'(S_LO);
        end
        else
        begin
            acc_sat = SB'(acc_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_tag.vld)
        begin
            acc_reg <= acc_next;
            if (sum_tag.last && !sum_tag.ch)
            begin
                left_reg <= acc_sat;
            end
            if (sum_tag.last && sum_tag.ch)
            begin
                right_reg <= acc_sat;
            end
        end
        if (rsp_load)
        begin
            rsp_item_reg.out_left       <= left_reg;
            rsp_item_reg.out_right      <= right_reg;
            rsp_item_reg.block_last_out <= last_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

`ifndef SYNTHESIS
    a_fin_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> state_reg == pbeq_pkg::ST_DRAIN)
        else $error("final band contribution outside drain");

    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> !rd_tag_reg.vld && !wb_tag.vld && !sum_tag.vld)
        else $error("item accepted while band pipeline busy");

    a_rsp_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == pbeq_pkg::ST_FLUSH)
        else $error("result raised outside flush");

    a_wb_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wb_tag.vld |-> state_reg != pbeq_pkg::ST_IDLE)
        else $error("history write-back while idle");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the parallel band-pass biquad equalizer core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BANDS        = pbeq_pkg::BAND_COUNT_DEF;
    localparam int SAMPLE_BITS  = pbeq_pkg::SAMPLE_BITS;
    localparam int CF           = pbeq_pkg::CF;
    localparam int GF           = pbeq_pkg::GF;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 2 * BANDS + 16;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int SMP_MAX      = (1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN      = -SMP_MAX - 1;
    localparam int WORD_MAX     = 32'sh7fffffff;
    localparam int WORD_MIN     = 32'sh80000000;
    localparam int ONE_Q28      = 1 <<< CF;
    localparam int DEFAULT_GAIN = ((636 <<< GF) + 500) / 1000;

    class eq_scoreboard;
        longint fb_coef[BANDS];
        longint in_coef[BANDS];
        longint rec_coef[BANDS];
        longint band_gain[BANDS];
        longint x_d1[2*BANDS];
        longint x_d2[2*BANDS];
        longint y_d1[2*BANDS];
        longint y_d2[2*BANDS];
        pbeq_pkg::out_item_t expected_q[$];
        int samples;
        int writes;
        int clears;
        int ignored;
        int checked;
        int errors;

        function new();
            for (int b = 0; b < BANDS; b++)
            begin
                fb_coef[b]   = 0;
                in_coef[b]   = 0;
                rec_coef[b]  = 0;
                band_gain[b] = DEFAULT_GAIN;
            end
            clear_histories();
        endfunction

        function void clear_histories();
            for (int h = 0; h < 2 * BANDS; h++)
            begin
                x_d1[h] = 0;
                x_d2[h] = 0;
                y_d1[h] = 0;
                y_d2[h] = 0;
            end
        endfunction

        function longint saturate(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function longint filter_channel(longint x, int ch);
            longint total;
            longint p0;
            longint p1;
            longint p2;
            longint acc;
            longint y;
            int h;
            total = 0;
            for (int b = 0; b < BANDS; b++)
            begin
                h   = ch * BANDS + b;
                p2  = rec_coef[b] * y_d1[h];
                p1  = in_coef[b] * (x - x_d2[h]);
                p0  = fb_coef[b] * y_d2[h];
                acc = (p2 >>> 2) + (p1 >>> 2) - (p0 >>> 2);
                y   = saturate((acc + (longint'(1) <<< (CF - 3))) >>> (CF - 2), 32);
                x_d2[h] = x_d1[h];
                x_d1[h] = x;
                y_d2[h] = y_d1[h];
                y_d1[h] = y;
                total += (y * band_gain[b] + (longint'(1) <<< (GF - 1))) >>> GF;
            end
            return saturate(total, SAMPLE_BITS);
        endfunction

        function void note_input(pbeq_pkg::in_item_t it);
            pbeq_pkg::out_item_t want;
            longint v;
            case (it.req_type)
                pbeq_pkg::REQ_SAMPLE:
                begin
                    want.out_left  = SAMPLE_BITS'(
                        filter_channel(longint'($signed(it.sample_left)), 0));
                    want.out_right = SAMPLE_BITS'(
                        filter_channel(longint'($signed(it.sample_right)), 1));
                    want.block_last_out = it.block_last_in;
                    expected_q.push_back(want);
                    samples++;
                end
                pbeq_pkg::REQ_WRITE:
                begin
                    v = longint'($signed(it.table_value));
                    if (it.band_index < BANDS)
                    begin
                        case (it.table_select)
                            pbeq_pkg::SEL_FEEDBACK:  fb_coef[it.band_index]   = v;
                            pbeq_pkg::SEL_INPUT:     in_coef[it.band_index]   = v;
                            pbeq_pkg::SEL_RECURSION: rec_coef[it.band_index]  = v;
                            default:                 band_gain[it.band_index] = v;
                        endcase
                        writes++;
                    end
                    else
                        ignored++;
                end
                pbeq_pkg::REQ_CLEAR:
                begin
                    clear_histories();
                    clears++;
                end
                default:
                    ignored++;
            endcase
        endfunction

        function void check_result(pbeq_pkg::out_item_t got);
            pbeq_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: out_left %0d out_right %0d",
                       $signed(got.out_left), $signed(got.out_right));
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.out_left !== want.out_left)
            begin
                $error("out_left: expected %0d, got %0d",
                       $signed(want.out_left), $signed(got.out_left));
                errors++;
            end
            if (got.out_right !== want.out_right)
            begin
                $error("out_right: expected %0d, got %0d",
                       $signed(want.out_right), $signed(got.out_right));
                errors++;
            end
            if (got.block_last_out !== want.block_last_out)
            begin
                $error("block_last_out: expected %0b, got %0b",
                       want.block_last_out, got.block_last_out);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    pbeq_pkg::in_item_t  req_item = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    pbeq_pkg::out_item_t rsp_item;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    eq_scoreboard sb = new();

    parallel_bandpass_biquad_eq_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp_item);
        if (rst_n && req_valid && req_ready)
            sb.note_input(req_item);
    end

    function automatic pbeq_pkg::in_item_t random_fields();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return pbeq_pkg::in_item_t'(raw[$bits(pbeq_pkg::in_item_t)-1:0]);
    endfunction

    function automatic pbeq_pkg::in_item_t sample_item(int l, int r, bit last);
        pbeq_pkg::in_item_t it;
        it = random_fields();
        it.req_type      = pbeq_pkg::REQ_SAMPLE;
        it.sample_left   = SAMPLE_BITS'(l);
        it.sample_right  = SAMPLE_BITS'(r);
        it.block_last_in = last;
        return it;
    endfunction

    function automatic pbeq_pkg::in_item_t write_item(int band, logic [1:0] sel, int value);
        pbeq_pkg::in_item_t it;
        it = random_fields();
        it.req_type     = pbeq_pkg::REQ_WRITE;
        it.band_index   = 4'(band);
        it.table_select = sel;
        it.table_value  = value;
        return it;
    endfunction

    function automatic pbeq_pkg::in_item_t bare_item(logic [1:0] req);
        pbeq_pkg::in_item_t it;
        it = random_fields();
        it.req_type = req;
        return it;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(5))
            0:       return SAMPLE_BITS'($urandom_range(1) ? SMP_MAX : SMP_MIN);
            1, 2:    return SAMPLE_BITS'($urandom);
            default: return SAMPLE_BITS'(int'($urandom_range(131071)) - 65536);
        endcase
    endfunction

    // keep sections stable: poles inside the unit circle, modest gains
    function automatic logic signed [31:0] pick_coeff(logic [1:0] sel);
        case (sel)
            pbeq_pkg::SEL_FEEDBACK:  return $urandom_range(265751101, 134217728);
            pbeq_pkg::SEL_INPUT:     return int'($urandom_range(268435456)) - 134217728;
            pbeq_pkg::SEL_RECURSION: return int'($urandom_range(778484120)) - 389242060;
            default:                 return int'($urandom_range(8388608)) - 4194304;
        endcase
    endfunction

    task automatic send_item(input pbeq_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(sample_item(0, 0, 1'b1));
        send_item(write_item(0, pbeq_pkg::SEL_INPUT, ONE_Q28));
        send_item(sample_item(SMP_MAX, SMP_MIN, 1'b0));
        send_item(sample_item(SMP_MIN, SMP_MAX, 1'b1));
        send_item(write_item(9, pbeq_pkg::SEL_RECURSION, 402653184));
        send_item(write_item(9, pbeq_pkg::SEL_FEEDBACK, 241591910));
        send_item(write_item(9, pbeq_pkg::SEL_INPUT, 67108864));
        send_item(write_item(9, pbeq_pkg::SEL_GAIN, WORD_MAX));
        send_item(sample_item(SMP_MAX, SMP_MAX, 1'b0));
        send_item(sample_item(SMP_MIN, SMP_MIN, 1'b1));
        send_item(write_item(10, pbeq_pkg::SEL_INPUT, WORD_MIN));
        send_item(write_item(15, pbeq_pkg::SEL_GAIN, 0));
        send_item(bare_item(REQ_UNUSED));
        send_item(write_item(4, pbeq_pkg::SEL_FEEDBACK, WORD_MIN));
        send_item(write_item(4, pbeq_pkg::SEL_INPUT, WORD_MAX));
        send_item(sample_item(SMP_MAX, SMP_MIN, 1'b1));
        send_item(sample_item(SMP_MIN, SMP_MAX, 1'b0));
        send_item(bare_item(pbeq_pkg::REQ_CLEAR));
        send_item(write_item(9, pbeq_pkg::SEL_GAIN, WORD_MIN));
        send_item(sample_item(SMP_MAX, 0, 1'b1));
        send_item(write_item(4, pbeq_pkg::SEL_INPUT, 0));
        send_item(write_item(9, pbeq_pkg::SEL_GAIN, DEFAULT_GAIN));
        send_item(bare_item(pbeq_pkg::REQ_CLEAR));
        send_item(sample_item(1, -1, 1'b0));
    endtask

    task automatic random_phase(input int send_pct, input int stall_pct, input int count);
        int done;
        int pick;
        pbeq_pkg::in_item_t it;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < count)
        begin
            it   = random_fields();
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                it.req_type     = pbeq_pkg::REQ_SAMPLE;
                it.sample_left  = pick_sample();
                it.sample_right = pick_sample();
            end
            else if (pick < 85)
            begin
                it.req_type    = pbeq_pkg::REQ_WRITE;
                it.band_index  = 4'($urandom_range(BANDS - 1));
                it.table_value = pick_coeff(it.table_select);
            end
            else if (pick < 86)
            begin
                it.req_type = pbeq_pkg::REQ_WRITE;
            end
            else if (pick < 92)
            begin
                it.req_type = pbeq_pkg::REQ_CLEAR;
            end
            else
            begin
                it.req_type = $urandom_range(1) ? REQ_UNUSED : pbeq_pkg::REQ_WRITE;
                it.band_index = 4'($urandom_range(15, BANDS));
            end
            send_item(it);
            done++;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        random_phase(0, 0, RANDOM_ITEMS / 4);
        random_phase(51, 0, RANDOM_ITEMS / 4);
        random_phase(0, 51, RANDOM_ITEMS / 4);
        random_phase(14, 14, RANDOM_ITEMS / 4);
        req_valid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d equalized samples; applied %0d table writes and %0d clears,",
                 sb.checked, sb.writes, sb.clears);
        $display("dropped %0d ignored requests, %0d mismatches, across four pressure mixes.",
                 sb.ignored, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
